/* hdl/sshc_pkg.sv */
package sshc_pkg;

  // Preset slot storage
  localparam int PRESET_SLOTS = 2;
  localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;

  // Field widths
  localparam int CMD_W   = 4;
  localparam int TEMP_W  = 9;
  localparam int SPEED_W = 3;
  localparam int DUTY_W  = 10;
  localparam int FTMR_W  = 13;
  localparam int SHOW_W  = 8;
  localparam int LIMIT_W = 20;
  localparam int IDLE_W  = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  // Setpoint limits and steps
  localparam logic [TEMP_W-1:0] IRON_MIN    = 9'd50;
  localparam logic [TEMP_W-1:0] IRON_MAX    = 9'd350;
  localparam logic [TEMP_W-1:0] AIR_MIN     = 9'd50;
  localparam logic [TEMP_W-1:0] AIR_MAX     = 9'd500;
  localparam logic [TEMP_W-1:0] AIR_UP_MAX  = 9'd450;
  localparam logic [TEMP_W-1:0] AIR_DN_MIN  = 9'd80;
  localparam logic [TEMP_W-1:0] SP_STEP     = 9'd5;
  localparam logic [TEMP_W-1:0] DEF_SP      = 9'd100;
  localparam logic [SPEED_W-1:0] SPEED_MIN  = 3'd1;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 3'd7;
  localparam logic [SPEED_W-1:0] DEF_SPEED  = 3'd1;

  // Timer defaults
  localparam logic [FTMR_W-1:0]  DEF_FAN_TIMEOUT = 13'd6000;
  localparam logic [SHOW_W-1:0]  DEF_SHOW_TICKS  = 8'd100;
  localparam logic [LIMIT_W-1:0] DEF_IDLE_LIMIT  = 20'd300000;
  localparam logic [IDLE_W-1:0]  IDLE_SAT        = {IDLE_W{1'b1}};

  // Drive constants
  localparam logic [DUTY_W-1:0] FAN_BASE     = 10'h1B0;
  localparam logic [DUTY_W-1:0] FAN_PER_STEP = 10'd80;
  localparam logic [DUTY_W-1:0] DUTY_FULL    = 10'd1023;
  localparam logic [DUTY_W-1:0] HEAT_BAND    = 10'd30;
  localparam logic [DUTY_W-1:0] OVER_BAND    = 10'd10;
  localparam logic [DUTY_W-1:0] HYST         = 10'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 4'd0,
    CMD_UP         = 4'd1,
    CMD_DOWN       = 4'd2,
    CMD_FAN_UP     = 4'd3,
    CMD_FAN_DOWN   = 4'd4,
    CMD_LOAD0      = 4'd5,
    CMD_LOAD1      = 4'd6,
    CMD_SAVE0      = 4'd7,
    CMD_SAVE1      = 4'd8,
    CMD_DEVICE     = 4'd9,
    CMD_POWER      = 4'd10,
    CMD_FAN_TOGGLE = 4'd11,
    CMD_FAN_ACTIVE = 4'd12
  } cmd_t;

  typedef enum logic [1:0] {
    FAN_OFF  = 2'd0,
    FAN_COOL = 2'd1,
    FAN_RUN  = 2'd2
  } fan_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_IRON   = 3'd0,
    REG_INIT_AIR    = 3'd1,
    REG_INIT_SPEED  = 3'd2,
    REG_FAN_TIMEOUT = 3'd3,
    REG_SHOW_TICKS  = 3'd4,
    REG_IDLE_LIMIT  = 3'd5
  } cfg_reg_t;

  // State seen by the drive logic after a tick
  typedef struct packed {
    logic              power;
    fan_mode_t         fan_mode;
    logic [TEMP_W-1:0] iron_sp;
    logic [TEMP_W-1:0] air_sp;
    logic [SPEED_W-1:0] speed;
  } ctl_state_t;

  // Heater and fan drives
  typedef struct packed {
    logic [DUTY_W-1:0] heater_duty;
    logic              air_heater_on;
    logic [DUTY_W-1:0] fan_duty;
  } drive_t;

endpackage

/* hdl/sshc_if.sv */
interface sshc_in_if;
  import sshc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TEMP_W-1:0] iron_measured;
  logic [TEMP_W-1:0] air_measured;
  modport source (output valid, cmd, iron_measured, air_measured, input ready);
  modport sink   (input valid, cmd, iron_measured, air_measured, output ready);
endinterface

interface sshc_out_if;
  import sshc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  heater_duty;
  logic               air_heater_on;
  logic [DUTY_W-1:0]  fan_duty;
  logic               power_on;
  logic               selected_device;
  logic [1:0]         fan_mode;
  logic               show_setpoint;
  logic [TEMP_W-1:0]  iron_setpoint;
  logic [TEMP_W-1:0]  air_setpoint;
  logic [SPEED_W-1:0] fan_speed;
  modport source (output valid, heater_duty, air_heater_on, fan_duty, power_on,
                  selected_device, fan_mode, show_setpoint, iron_setpoint,
                  air_setpoint, fan_speed, input ready);
  modport sink   (input valid, heater_duty, air_heater_on, fan_duty, power_on,
                  selected_device, fan_mode, show_setpoint, iron_setpoint,
                  air_setpoint, fan_speed, output ready);
endinterface

interface sshc_cfg_if;
  import sshc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sshc_drive.sv */
module sshc_drive
  import sshc_pkg::*;
(
  input  ctl_state_t        st,
  input  logic [TEMP_W-1:0] iron_measured,
  input  logic [TEMP_W-1:0] air_measured,
  output drive_t            drv
);

  logic [DUTY_W-1:0] sp;
  logic [DUTY_W-1:0] meas;
  logic [DUTY_W-1:0] speed_term;

  assign sp   = {1'b0, st.iron_sp};
  assign meas = {1'b0, iron_measured};
  // speed * 80 as shifts: 64 + 16
  assign speed_term = DUTY_W'({st.speed, 6'b0}) + DUTY_W'({st.speed, 4'b0});

  always_comb begin
    drv = '0;
    if (st.power) begin
      // hot air heater runs only with the fan spinning
      drv.air_heater_on = (st.air_sp > air_measured) && (st.fan_mode != FAN_OFF);

      case (st.fan_mode)
        FAN_COOL: drv.fan_duty = FAN_BASE;
        FAN_RUN:  drv.fan_duty = FAN_BASE + speed_term;
        default:  drv.fan_duty = '0;
      endcase

      // coarse bang-bang on the iron: full below the band, off well above, else 2x or 1x setpoint
      if (sp + HYST > meas) begin
        drv.heater_duty = (sp > meas + HEAT_BAND) ? DUTY_FULL : {sp[DUTY_W-2:0], 1'b0};
      end else begin
        drv.heater_duty = (meas > sp + OVER_BAND) ? '0 : sp;
      end
    end
  end

endmodule

/* hdl/station_setpoint_and_heater_control_core.sv */
// Setpoint and heater control for a two-tool soldering station.
// One request on the tick channel is one control loop tick: a command code
// (0 = none) and the measured iron and hot air temperatures. Each request
// produces exactly one result on the result channel: heater duty, air heater
// enable, fan duty, and the status/setpoint fields after the tick.
// The cfg channel writes the six setup registers by index; it is always ready
// and should only be used while no tick is in flight. Writing an init register
// also reloads the current value and every preset slot of that kind.
// Each tick passes through the input register, then the result register.
// Throughput: one tick per cycle while results are taken, set by the single
// state update path between the input register and the result register.
// If the result receiver stalls, the finished result holds and one more tick
// can still be taken into the input register; tick ready drops only when both
// stages are full. Reset (rst, synchronous) clears both stages, powers the
// unit off, stops the fan, clears the timers and loads setpoints 100/100 and
// fan speed 1 into the working and preset registers.
module station_setpoint_and_heater_control_core
  import sshc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sshc_in_if.sink    tick,
  sshc_out_if.source result,
  sshc_cfg_if.sink   cfg
);

  // Setup registers
  logic [FTMR_W-1:0]  run_ticks;
  logic [SHOW_W-1:0]  show_ticks;
  logic [LIMIT_W-1:0] idle_limit;

  // Control state
  logic               power_state;
  logic               device_select;
  fan_mode_t          fan_state;
  logic [FTMR_W-1:0]  fan_timer;
  logic [SHOW_W-1:0]  show_timer;
  logic [IDLE_W-1:0]  idle_counter;
  logic [TEMP_W-1:0]  iron_target;
  logic [TEMP_W-1:0]  air_target;
  logic [SPEED_W-1:0] speed_step;
  logic [TEMP_W-1:0]  preset_iron  [PRESET_SLOTS];
  logic [TEMP_W-1:0]  preset_air   [PRESET_SLOTS];
  logic [SPEED_W-1:0] preset_speed [PRESET_SLOTS];

  logic               power_state_next;
  logic               device_select_next;
  fan_mode_t          fan_state_next;
  logic [FTMR_W-1:0]  fan_timer_next;
  logic [SHOW_W-1:0]  show_timer_next;
  logic [IDLE_W-1:0]  idle_counter_next;
  logic [TEMP_W-1:0]  iron_target_next;
  logic [TEMP_W-1:0]  air_target_next;
  logic [SPEED_W-1:0] speed_step_next;
  logic [TEMP_W-1:0]  preset_iron_next  [PRESET_SLOTS];
  logic [TEMP_W-1:0]  preset_air_next   [PRESET_SLOTS];
  logic [SPEED_W-1:0] preset_speed_next [PRESET_SLOTS];

  // Input stage
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [TEMP_W-1:0] s1_iron_meas;
  logic [TEMP_W-1:0] s1_air_meas;

  logic       advance;
  logic       tick_take;
  logic       slot;
  logic       slot_ok;
  ctl_state_t st_next;
  drive_t     drv;

  // Config write decode
  logic               cfg_take;
  logic [TEMP_W-1:0]  cfg_iron;
  logic [TEMP_W-1:0]  cfg_air;
  logic [SPEED_W-1:0] cfg_speed;

  assign advance   = s1_valid && (!result.valid || result.ready);
  assign tick.ready = !s1_valid || advance;
  assign tick_take = tick.valid && tick.ready;
  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid;

  assign cfg_iron  = (cfg.data[TEMP_W-1:0] > IRON_MAX || cfg.data[TEMP_W-1:0] < IRON_MIN) ?
                     DEF_SP : cfg.data[TEMP_W-1:0];
  assign cfg_air   = (cfg.data[TEMP_W-1:0] > AIR_MAX || cfg.data[TEMP_W-1:0] < AIR_MIN) ?
                     DEF_SP : cfg.data[TEMP_W-1:0];
  assign cfg_speed = (cfg.data[SPEED_W-1:0] < SPEED_MIN) ? DEF_SPEED : cfg.data[SPEED_W-1:0];

  // Load/save slot from the command: slot 1 for LOAD1 and SAVE1, else slot 0
  always_comb begin
    case (cmd_t'(s1_cmd))
      CMD_LOAD1, CMD_SAVE1: slot = 1'b1;
      default:              slot = 1'b0;
    endcase
    slot_ok = (PRESET_SLOTS > 1) || !slot;
  end

  // One tick of state update
  always_comb begin
    power_state_next   = power_state;
    device_select_next = device_select;
    fan_state_next     = fan_state;
    fan_timer_next     = fan_timer;
    show_timer_next    = show_timer;
    idle_counter_next  = idle_counter;
    iron_target_next   = iron_target;
    air_target_next    = air_target;
    speed_step_next    = speed_step;
    preset_iron_next   = preset_iron;
    preset_air_next    = preset_air;
    preset_speed_next  = preset_speed;

    // any command restarts display and idle timing
    if (cmd_t'(s1_cmd) != CMD_NONE) begin
      show_timer_next   = show_ticks;
      idle_counter_next = '0;
    end

    if (power_state || cmd_t'(s1_cmd) == CMD_POWER) begin
      case (cmd_t'(s1_cmd))
        CMD_UP: begin
          if (device_select) begin
            air_target_next = (air_target < AIR_UP_MAX) ? air_target + SP_STEP : AIR_UP_MAX;
          end else begin
            iron_target_next = (iron_target < IRON_MAX) ? iron_target + SP_STEP : IRON_MAX;
          end
        end
        CMD_DOWN: begin
          if (device_select) begin
            air_target_next = (air_target > AIR_DN_MIN) ? air_target - SP_STEP : AIR_DN_MIN;
          end else begin
            iron_target_next = (iron_target > IRON_MIN) ? iron_target - SP_STEP : IRON_MIN;
          end
        end
        CMD_FAN_UP: begin
          if (speed_step < SPEED_MAX) speed_step_next = speed_step + 1'b1;
          device_select_next = 1'b1;
        end
        CMD_FAN_DOWN: begin
          if (speed_step > SPEED_MIN) speed_step_next = speed_step - 1'b1;
          device_select_next = 1'b1;
        end
        CMD_LOAD0, CMD_LOAD1: begin
          if (slot_ok) begin
            if (device_select) begin
              air_target_next = preset_air[SLOT_W'(slot)];
              speed_step_next = preset_speed[SLOT_W'(slot)];
            end else begin
              iron_target_next = preset_iron[SLOT_W'(slot)];
            end
          end
        end
        CMD_SAVE0, CMD_SAVE1: begin
          if (slot_ok) begin
            if (device_select) begin
              preset_air_next[SLOT_W'(slot)]   = air_target;
              preset_speed_next[SLOT_W'(slot)] = speed_step;
            end else begin
              preset_iron_next[SLOT_W'(slot)] = iron_target;
            end
          end
        end
        CMD_DEVICE: device_select_next = !device_select;
        CMD_POWER: begin
          if (power_state) begin
            fan_state_next   = FAN_OFF;
            power_state_next = 1'b0;
          end else begin
            power_state_next   = 1'b1;
            device_select_next = 1'b0;
          end
        end
        CMD_FAN_TOGGLE: begin
          if (fan_state != FAN_OFF) begin
            fan_state_next     = FAN_OFF;
            device_select_next = 1'b0;
          end else begin
            fan_state_next     = FAN_RUN;
            device_select_next = 1'b1;
            fan_timer_next     = run_ticks;
          end
        end
        CMD_FAN_ACTIVE: begin
          if (fan_state == FAN_COOL) fan_state_next = FAN_RUN;
          fan_timer_next     = run_ticks;
          device_select_next = 1'b1;
        end
        default: ;
      endcase

      // fan run timeout drops back to cooldown
      if (fan_timer_next != '0) begin
        fan_timer_next = fan_timer_next - 1'b1;
      end else if (fan_state_next != FAN_OFF) begin
        fan_state_next = FAN_COOL;
      end
      if (show_timer_next != '0) show_timer_next = show_timer_next - 1'b1;
      if (idle_counter_next != IDLE_SAT) idle_counter_next = idle_counter_next + 1'b1;
      // auto power off
      if (idle_counter_next > {1'b0, idle_limit}) begin
        power_state_next = 1'b0;
        fan_state_next   = FAN_OFF;
      end
    end
  end

  assign st_next = '{power:    power_state_next,
                     fan_mode: fan_state_next,
                     iron_sp:  iron_target_next,
                     air_sp:   air_target_next,
                     speed:    speed_step_next};

  sshc_drive u_drive (
    .st            (st_next),
    .iron_measured (s1_iron_meas),
    .air_measured  (s1_air_meas),
    .drv           (drv)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
    if (tick_take) begin
      s1_cmd       <= tick.cmd;
      s1_iron_meas <= tick.iron_measured;
      s1_air_meas  <= tick.air_measured;
    end
  end

  // State and setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_ticks     <= DEF_FAN_TIMEOUT;
      show_ticks    <= DEF_SHOW_TICKS;
      idle_limit    <= DEF_IDLE_LIMIT;
      power_state   <= 1'b0;
      device_select <= 1'b0;
      fan_state     <= FAN_OFF;
      fan_timer     <= '0;
      show_timer    <= '0;
      idle_counter  <= '0;
      iron_target   <= DEF_SP;
      air_target    <= DEF_SP;
      speed_step    <= DEF_SPEED;
      for (int i = 0; i < PRESET_SLOTS; i++) begin
        preset_iron[i]  <= DEF_SP;
        preset_air[i]   <= DEF_SP;
        preset_speed[i] <= DEF_SPEED;
      end
    end else begin
      if (advance) begin
        power_state   <= power_state_next;
        device_select <= device_select_next;
        fan_state     <= fan_state_next;
        fan_timer     <= fan_timer_next;
        show_timer    <= show_timer_next;
        idle_counter  <= idle_counter_next;
        iron_target   <= iron_target_next;
        air_target    <= air_target_next;
        speed_step    <= speed_step_next;
        preset_iron   <= preset_iron_next;
        preset_air    <= preset_air_next;
        preset_speed  <= preset_speed_next;
      end
      if (cfg_take) begin
        case (cfg_reg_t'(cfg.index))
          REG_INIT_IRON: begin
            iron_target <= cfg_iron;
            for (int i = 0; i < PRESET_SLOTS; i++) preset_iron[i] <= cfg_iron;
          end
          REG_INIT_AIR: begin
            air_target <= cfg_air;
            for (int i = 0; i < PRESET_SLOTS; i++) preset_air[i] <= cfg_air;
          end
          REG_INIT_SPEED: begin
            speed_step <= cfg_speed;
            for (int i = 0; i < PRESET_SLOTS; i++) preset_speed[i] <= cfg_speed;
          end
          REG_FAN_TIMEOUT: run_ticks   <= cfg.data[FTMR_W-1:0];
          REG_SHOW_TICKS:  show_ticks  <= cfg.data[SHOW_W-1:0];
          REG_IDLE_LIMIT:  idle_limit  <= cfg.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (advance) begin
      result.heater_duty     <= drv.heater_duty;
      result.air_heater_on   <= drv.air_heater_on;
      result.fan_duty        <= drv.fan_duty;
      result.power_on        <= power_state_next;
      result.selected_device <= device_select_next;
      result.fan_mode        <= fan_state_next;
      result.show_setpoint   <= (show_timer_next != '0);
      result.iron_setpoint   <= iron_target_next;
      result.air_setpoint    <= air_target_next;
      result.fan_speed       <= speed_step_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted tick is in the input stage next cycle
  a_tick_loaded: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> s1_valid)
    else $error("accepted tick did not reach the input stage");

  // a tick that moves on always shows up as a result
  a_result_made: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("tick advanced without a result");

  // unpowered unit drives nothing
  a_off_no_drive: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.power_on) |->
      (result.heater_duty == '0 && result.fan_duty == '0 && !result.air_heater_on))
    else $error("drive active while powered off");

  // fan off means no fan duty and no air heater
  a_fan_off: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.fan_mode == FAN_OFF) |->
      (result.fan_duty == '0 && !result.air_heater_on))
    else $error("fan drive active with fan off");
`endif

endmodule

/* dv/station_setpoint_and_heater_control_core_tb.sv */
`timescale 1ns / 100ps

module station_setpoint_and_heater_control_core_tb;
  import sshc_pkg::*;

  // Command codes past the defined set, and config indexes with no register
  localparam logic [CMD_W-1:0]     CMD_RSVD_LO  = 4'd13;
  localparam logic [CMD_W-1:0]     CMD_RSVD_HI  = 4'd15;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 9;
  localparam int PHASE_TICKS = 200;
  localparam int PRINT_MAX   = 30;

  typedef struct {
    logic [DUTY_W-1:0]  heater_duty;
    logic               air_heater_on;
    logic [DUTY_W-1:0]  fan_duty;
    logic               power_on;
    logic               selected_device;
    logic [1:0]         fan_mode;
    logic               show_setpoint;
    logic [TEMP_W-1:0]  iron_setpoint;
    logic [TEMP_W-1:0]  air_setpoint;
    logic [SPEED_W-1:0] fan_speed;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;

  sshc_in_if  tick_if();
  sshc_out_if res_if();
  sshc_cfg_if cfg_if();

  station_setpoint_and_heater_control_core u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #1 clk = ~clk;

  // Mirror of the controller state and setup registers
  logic               m_power;
  logic               m_dev;
  fan_mode_t          m_fan;
  logic [FTMR_W-1:0]  m_fan_tmr;
  logic [SHOW_W-1:0]  m_show_tmr;
  logic [IDLE_W-1:0]  m_idle;
  logic [TEMP_W-1:0]  m_iron_sp;
  logic [TEMP_W-1:0]  m_air_sp;
  logic [SPEED_W-1:0] m_speed;
  logic [TEMP_W-1:0]  m_preset_iron [PRESET_SLOTS];
  logic [TEMP_W-1:0]  m_preset_air [PRESET_SLOTS];
  logic [SPEED_W-1:0] m_preset_speed [PRESET_SLOTS];
  logic [FTMR_W-1:0]  r_run_ticks;
  logic [SHOW_W-1:0]  r_show_ticks;
  logic [LIMIT_W-1:0] r_idle_limit;

  tick_result_t pending_results[$];
  int mismatches   = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  // Stimulus pacing controls
  int burst_left   = 0;
  int hold_request = 0;
  bit sender_gaps  = 1'b1;
  bit sink_stalls  = 1'b1;

  // ---------------------------------------------------------------------------
  // Controller mirror
  // ---------------------------------------------------------------------------
  function automatic void station_reset();
    m_power = 1'b0;
    m_dev = 1'b0;
    m_fan = FAN_OFF;
    m_fan_tmr = '0;
    m_show_tmr = '0;
    m_idle = '0;
    m_iron_sp = DEF_SP;
    m_air_sp = DEF_SP;
    m_speed = DEF_SPEED;
    foreach (m_preset_iron[i]) begin
      m_preset_iron[i] = DEF_SP;
      m_preset_air[i] = DEF_SP;
      m_preset_speed[i] = DEF_SPEED;
    end
    r_run_ticks = DEF_FAN_TIMEOUT;
    r_show_ticks = DEF_SHOW_TICKS;
    r_idle_limit = DEF_IDLE_LIMIT;
  endfunction

  // Init registers also reload the working value and every preset slot
  function automatic void station_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DAT_W-1:0] d);
    logic [TEMP_W-1:0]  t;
    logic [SPEED_W-1:0] s;
    case (idx)
      REG_INIT_IRON: begin
        t = d[TEMP_W-1:0];
        if (t > IRON_MAX || t < IRON_MIN) t = DEF_SP;
        m_iron_sp = t;
        foreach (m_preset_iron[i]) m_preset_iron[i] = t;
      end
      REG_INIT_AIR: begin
        t = d[TEMP_W-1:0];
        if (t > AIR_MAX || t < AIR_MIN) t = DEF_SP;
        m_air_sp = t;
        foreach (m_preset_air[i]) m_preset_air[i] = t;
      end
      REG_INIT_SPEED: begin
        s = d[SPEED_W-1:0];
        if (s > SPEED_MAX || s < SPEED_MIN) s = DEF_SPEED;
        m_speed = s;
        foreach (m_preset_speed[i]) m_preset_speed[i] = s;
      end
      REG_FAN_TIMEOUT: r_run_ticks = d[FTMR_W-1:0];
      REG_SHOW_TICKS:  r_show_ticks = d[SHOW_W-1:0];
      REG_IDLE_LIMIT:  r_idle_limit = d[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // One loop tick: command, timers, then drives from the new state
  function automatic tick_result_t station_tick(logic [CMD_W-1:0] c,
                                                logic [TEMP_W-1:0] im,
                                                logic [TEMP_W-1:0] am);
    tick_result_t r;
    int slot;
    int sp;
    int meas;
    r = '{default: '0};
    if (c != CMD_NONE) begin
      m_show_tmr = r_show_ticks;
      m_idle = '0;
    end
    if (m_power || c == CMD_POWER) begin
      case (c)
        CMD_UP: begin
          if (m_dev) m_air_sp = (m_air_sp < AIR_UP_MAX) ? m_air_sp + SP_STEP : AIR_UP_MAX;
          else m_iron_sp = (m_iron_sp < IRON_MAX) ? m_iron_sp + SP_STEP : IRON_MAX;
        end
        CMD_DOWN: begin
          if (m_dev) m_air_sp = (m_air_sp > AIR_DN_MIN) ? m_air_sp - SP_STEP : AIR_DN_MIN;
          else m_iron_sp = (m_iron_sp > IRON_MIN) ? m_iron_sp - SP_STEP : IRON_MIN;
        end
        CMD_FAN_UP: begin
          if (m_speed < SPEED_MAX) m_speed = m_speed + 1'b1;
          m_dev = 1'b1;
        end
        CMD_FAN_DOWN: begin
          if (m_speed > SPEED_MIN) m_speed = m_speed - 1'b1;
          m_dev = 1'b1;
        end
        CMD_LOAD0, CMD_LOAD1: begin
          slot = int'(c) - int'(CMD_LOAD0);
          if (slot < PRESET_SLOTS) begin
            if (m_dev) begin
              m_air_sp = m_preset_air[slot];
              m_speed = m_preset_speed[slot];
            end else begin
              m_iron_sp = m_preset_iron[slot];
            end
          end
        end
        CMD_SAVE0, CMD_SAVE1: begin
          slot = int'(c) - int'(CMD_SAVE0);
          if (slot < PRESET_SLOTS) begin
            if (m_dev) begin
              m_preset_air[slot] = m_air_sp;
              m_preset_speed[slot] = m_speed;
            end else begin
              m_preset_iron[slot] = m_iron_sp;
            end
          end
        end
        CMD_DEVICE: m_dev = ~m_dev;
        CMD_POWER: begin
          if (m_power) begin
            m_fan = FAN_OFF;
            m_power = 1'b0;
          end else begin
            m_power = 1'b1;
            m_dev = 1'b0;
          end
        end
        CMD_FAN_TOGGLE: begin
          if (m_fan != FAN_OFF) begin
            m_fan = FAN_OFF;
            m_dev = 1'b0;
          end else begin
            m_fan = FAN_RUN;
            m_dev = 1'b1;
            m_fan_tmr = r_run_ticks;
          end
        end
        CMD_FAN_ACTIVE: begin
          if (m_fan == FAN_COOL) m_fan = FAN_RUN;
          m_fan_tmr = r_run_ticks;
          m_dev = 1'b1;
        end
        default: ;
      endcase
      // fan run timeout falls back to cooldown
      if (m_fan_tmr != '0) m_fan_tmr = m_fan_tmr - 1'b1;
      else if (m_fan != FAN_OFF) m_fan = FAN_COOL;
      if (m_show_tmr != '0) m_show_tmr = m_show_tmr - 1'b1;
      if (m_idle != IDLE_SAT) m_idle = m_idle + 1'b1;
      if (m_idle > r_idle_limit) begin
        m_power = 1'b0;
        m_fan = FAN_OFF;
      end
    end

    if (m_power) begin
      sp = int'(m_iron_sp);
      meas = int'(im);
      r.air_heater_on = (m_air_sp > am) && (m_fan != FAN_OFF);
      if (m_fan == FAN_COOL) r.fan_duty = FAN_BASE;
      else if (m_fan == FAN_RUN)
        r.fan_duty = DUTY_W'(int'(m_speed) * int'(FAN_PER_STEP) + int'(FAN_BASE));
      // coarse bang-bang around the iron setpoint
      if (sp > meas - int'(HYST))
        r.heater_duty = (sp - meas > int'(HEAT_BAND)) ? DUTY_FULL : DUTY_W'(sp * 2);
      else
        r.heater_duty = (meas - sp > int'(OVER_BAND)) ? '0 : DUTY_W'(sp);
    end
    r.power_on = m_power;
    r.selected_device = m_dev;
    r.fan_mode = m_fan;
    r.show_setpoint = (m_show_tmr != '0);
    r.iron_setpoint = m_iron_sp;
    r.air_setpoint = m_air_sp;
    r.fan_speed = m_speed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // Sample all channels before the edge updates them
  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("heater_duty", res_if.heater_duty, want.heater_duty);
          check_field("air_heater_on", res_if.air_heater_on, want.air_heater_on);
          check_field("fan_duty", res_if.fan_duty, want.fan_duty);
          check_field("power_on", res_if.power_on, want.power_on);
          check_field("selected_device", res_if.selected_device, want.selected_device);
          check_field("fan_mode", res_if.fan_mode, want.fan_mode);
          check_field("show_setpoint", res_if.show_setpoint, want.show_setpoint);
          check_field("iron_setpoint", res_if.iron_setpoint, want.iron_setpoint);
          check_field("air_setpoint", res_if.air_setpoint, want.air_setpoint);
          check_field("fan_speed", res_if.fan_speed, want.fan_speed);
        end
        results_seen++;
      end
      if (cfg_if.valid && cfg_if.ready) station_reg_write(cfg_if.index, cfg_if.data);
      if (tick_if.valid && tick_if.ready)
        pending_results.push_back(station_tick(tick_if.cmd, tick_if.iron_measured,
                                               tick_if.air_measured));
      // watchdog on forward progress
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random ready runs, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int run;
    int held;
    logic level;
    run = 0;
    held = 0;
    level = 1'b1;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        res_if.ready <= 1'b0;
        held--;
      end else if (!sink_stalls) begin
        res_if.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          level = ~level;
          run = level ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run--;
        res_if.ready <= level;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one tick request; with sender_gaps set, sender idles between bursts
  task automatic send_tick(input logic [CMD_W-1:0] c, input logic [TEMP_W-1:0] im,
                           input logic [TEMP_W-1:0] am);
    tick_if.valid <= 1'b1;
    tick_if.cmd <= c;
    tick_if.iron_measured <= im;
    tick_if.air_measured <= am;
    do @(posedge clk); while (!tick_if.ready);
    if (sender_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        tick_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end
    end
  endtask

  // Stop offering and let every outstanding result drain
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write with random junk above the register's width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val,
                           input int w);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DAT_W'(({$urandom} << w) | val);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned iron, air, spd, ftmo, show, idle);
    write_reg(REG_INIT_IRON, iron, TEMP_W);
    write_reg(REG_INIT_AIR, air, TEMP_W);
    write_reg(REG_INIT_SPEED, spd, SPEED_W);
    write_reg(REG_FAN_TIMEOUT, ftmo, FTMR_W);
    write_reg(REG_SHOW_TICKS, show, SHOW_W);
    write_reg(REG_IDLE_LIMIT, idle, LIMIT_W);
    write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom, CFG_DAT_W);
  endtask

  // Extremes, an odd value anywhere in the field, or a typical value
  function automatic int unsigned pick(int unsigned lo, hi, typ, full);
    case ($urandom_range(0, 9))
      0, 1:    return lo;
      2, 3:    return hi;
      4:       return $urandom_range(0, full);
      default: return $urandom_range(lo, typ);
    endcase
  endfunction

  // Mostly near the setpoint so every heater band is hit
  function automatic logic [TEMP_W-1:0] near_temp(logic [TEMP_W-1:0] sp);
    int t;
    if ($urandom_range(0, 3) == 0) return TEMP_W'($urandom);
    t = int'(sp) + int'($urandom_range(0, 80)) - 40;
    if (t < 0) t = 0;
    if (t > (1 << TEMP_W) - 1) t = (1 << TEMP_W) - 1;
    return TEMP_W'(t);
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CMD_W_RSVD();
    return CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
  endfunction

  // Weighted command mix; a powered-off unit is usually switched back on
  function automatic logic [CMD_W-1:0] random_cmd();
    int r;
    if (!m_power && $urandom_range(0, 1)) return CMD_POWER;
    r = $urandom_range(0, 99);
    if (r < 15) return CMD_NONE;
    if (r < 35) return CMD_UP;
    if (r < 50) return CMD_DOWN;
    if (r < 56) return CMD_FAN_UP;
    if (r < 62) return CMD_FAN_DOWN;
    if (r < 66) return CMD_LOAD0;
    if (r < 70) return CMD_LOAD1;
    if (r < 74) return CMD_SAVE0;
    if (r < 78) return CMD_SAVE1;
    if (r < 83) return CMD_DEVICE;
    if (r < 85) return CMD_POWER;
    if (r < 90) return CMD_FAN_TOGGLE;
    if (r < 96) return CMD_FAN_ACTIVE;
    return CMD_CMD_W_RSVD();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every command at reset settings, measured extremes, all heater bands
  task automatic test_directed_commands();
    send_tick(CMD_NONE, 0, 0);
    send_tick(CMD_UP, 511, 511);        // ignored while off
    send_tick(CMD_POWER, 0, 0);
    send_tick(CMD_UP, 100, 0);
    send_tick(CMD_DOWN, 110, 0);
    send_tick(CMD_DOWN, 200, 511);
    send_tick(CMD_FAN_TOGGLE, 95, 0);
    send_tick(CMD_FAN_UP, 95, 511);
    send_tick(CMD_FAN_UP, 97, 99);
    send_tick(CMD_UP, 92, 99);
    send_tick(CMD_DOWN, 60, 105);
    send_tick(CMD_SAVE0, 511, 0);
    send_tick(CMD_FAN_DOWN, 0, 511);
    send_tick(CMD_SAVE1, 105, 100);
    send_tick(CMD_LOAD0, 86, 50);
    send_tick(CMD_LOAD1, 84, 300);
    send_tick(CMD_DEVICE, 95, 0);
    send_tick(CMD_SAVE1, 98, 0);
    send_tick(CMD_UP, 96, 0);
    send_tick(CMD_LOAD1, 95, 0);
    send_tick(CMD_FAN_ACTIVE, 95, 0);
    send_tick(CMD_RSVD_LO, 106, 511);
    send_tick(CMD_RSVD_HI, 104, 0);
    send_tick(CMD_FAN_TOGGLE, 95, 0);
    send_tick(CMD_POWER, 95, 0);
  endtask

  // Phases of random ticks, each under its own register setting
  task automatic test_register_phases();
    int unsigned iron, air, spd, ftmo, show, idle;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        // iron and air one step below the up clamps, so an up step overshoots them
        0: begin iron = 349; air = 449; spd = 7; ftmo = 1; show = 0; idle = 1048575; end
        1: begin iron = 50; air = 50; spd = 1; ftmo = 8191; show = 255; idle = 1; end
        // out of range init values fall back to defaults; zero fan timeout and idle limit
        2: begin iron = 0; air = 511; spd = 0; ftmo = 0; show = 1; idle = 0; end
        3: begin iron = 400; air = 501; spd = 7; ftmo = 5; show = 3; idle = 25; end
        default: begin
          iron = pick(50, 350, 350, 511);
          air = pick(50, 500, 500, 511);
          spd = pick(1, 7, 7, 7);
          ftmo = pick(1, 8191, 60, 8191);
          show = pick(0, 255, 20, 255);
          idle = pick(1, 1048575, 300, 1048575);
        end
      endcase
      configure(iron, air, spd, ftmo, show, idle);
      sender_gaps = (ph % 4 != 3);
      sink_stalls = (ph % 4 != 3);
      for (int k = 0; k < PHASE_TICKS; k++)
        send_tick(random_cmd(), near_temp(m_iron_sp), near_temp(m_air_sp));
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Long result hold-off while ticks keep coming: both stages fill
  task automatic test_output_backpressure();
    wait_idle();
    sender_gaps = 1'b0;
    hold_request = 200;
    for (int k = 0; k < 40; k++)
      send_tick(random_cmd(), near_temp(m_iron_sp), near_temp(m_air_sp));
    sender_gaps = 1'b1;
  endtask

  initial begin : test_sequence
    rst <= 1'b1;
    tick_if.valid <= 1'b0;
    tick_if.cmd <= CMD_NONE;
    tick_if.iron_measured <= '0;
    tick_if.air_measured <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_INIT_IRON;
    cfg_if.data <= '0;
    station_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_commands();
    test_output_backpressure();
    test_register_phases();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
